// ===== rtl/bed_pkg.sv =====
package bed_pkg;

  // field widths
  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int COUNT_W   = 8;
  localparam int MASK_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 32;

  // remainder loop: one quotient bit per step
  localparam int DIV_STEPS = TIME_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(50);

  // event bit positions
  localparam int EV_CHANGE  = 0;
  localparam int EV_FALLING = 1;
  localparam int EV_RISING  = 2;
  localparam int EV_HOLD    = 3;
  localparam int EV_MULTI   = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD  = 3'd0,
    CFG_INVERT_INPUT   = 3'd1,
    CFG_HOLD_DELAY     = 3'd2,
    CFG_MULTI_COUNT    = 3'd3,
    CFG_MULTI_WINDOW   = 3'd4,
    CFG_RELOAD_MODE    = 3'd5,
    CFG_CHANNEL_ENABLE = 3'd6,
    CFG_EVENT_MASK     = 3'd7
  } bed_cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] sample_period;
    logic                invert_input;
    logic [TIME_W-1:0]   hold_delay;
    logic [COUNT_W-1:0]  multi_count;
    logic [TIME_W-1:0]   multi_window;
    logic                reload_mode;
    logic                channel_enable;
    logic [MASK_W-1:0]   event_mask;
  } bed_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              raw_level;
  } bed_in_t;

  typedef struct packed {
    logic               sampled;
    logic               ev_change;
    logic               ev_falling;
    logic               ev_rising;
    logic               ev_hold;
    logic               ev_multi;
    logic [COUNT_W-1:0] click_count;
  } bed_out_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_LOAD,
    OP_NOP,
    OP_DIV,
    OP_ADVANCE,
    OP_EDGE,
    OP_PRESS_WIN,
    OP_PRESS_INC,
    OP_PRESS_MULTI,
    OP_RELOAD,
    OP_HOLD,
    OP_MASK,
    OP_EMIT
  } bed_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_LT_PERIOD,
    C_CNT_NZ,
    C_DISABLED,
    C_NOT_FELL,
    C_OUT_FREE
  } bed_cond_t;

  typedef logic [3:0] bed_upc_t;

  // program addresses
  localparam bed_upc_t UPC_WAIT        = 4'd0;
  localparam bed_upc_t UPC_LOAD        = 4'd1;
  localparam bed_upc_t UPC_CHECK       = 4'd2;
  localparam bed_upc_t UPC_DIV         = 4'd3;
  localparam bed_upc_t UPC_ADVANCE     = 4'd4;
  localparam bed_upc_t UPC_EDGE        = 4'd5;
  localparam bed_upc_t UPC_PRESS_WIN   = 4'd6;
  localparam bed_upc_t UPC_PRESS_INC   = 4'd7;
  localparam bed_upc_t UPC_PRESS_MULTI = 4'd8;
  localparam bed_upc_t UPC_RELOAD      = 4'd9;
  localparam bed_upc_t UPC_HOLD        = 4'd10;
  localparam bed_upc_t UPC_MASK        = 4'd11;
  localparam bed_upc_t UPC_DONE        = 4'd12;
  localparam bed_upc_t UPC_RETRY       = 4'd13;

  typedef struct packed {
    bed_op_t   op;
    bed_cond_t cond;
    bed_upc_t  target;
  } bed_uword_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic lt_period;
    logic disabled;
    logic not_fell;
    logic cnt_nz;
  } bed_stat_t;

  // microcode rom
  function automatic bed_uword_t bed_ucode(input bed_upc_t upc);
    bed_uword_t uw;
    case (upc)
      UPC_WAIT:        uw = '{op: OP_WAIT,        cond: C_NO_START,  target: UPC_WAIT};
      UPC_LOAD:        uw = '{op: OP_LOAD,        cond: C_NEXT,      target: UPC_WAIT};
      UPC_CHECK:       uw = '{op: OP_NOP,         cond: C_LT_PERIOD, target: UPC_DONE};
      UPC_DIV:         uw = '{op: OP_DIV,         cond: C_CNT_NZ,    target: UPC_DIV};
      UPC_ADVANCE:     uw = '{op: OP_ADVANCE,     cond: C_DISABLED,  target: UPC_DONE};
      UPC_EDGE:        uw = '{op: OP_EDGE,        cond: C_NOT_FELL,  target: UPC_RELOAD};
      UPC_PRESS_WIN:   uw = '{op: OP_PRESS_WIN,   cond: C_NEXT,      target: UPC_WAIT};
      UPC_PRESS_INC:   uw = '{op: OP_PRESS_INC,   cond: C_NEXT,      target: UPC_WAIT};
      UPC_PRESS_MULTI: uw = '{op: OP_PRESS_MULTI, cond: C_NEXT,      target: UPC_WAIT};
      UPC_RELOAD:      uw = '{op: OP_RELOAD,      cond: C_NEXT,      target: UPC_WAIT};
      UPC_HOLD:        uw = '{op: OP_HOLD,        cond: C_NEXT,      target: UPC_WAIT};
      UPC_MASK:        uw = '{op: OP_MASK,        cond: C_NEXT,      target: UPC_WAIT};
      UPC_DONE:        uw = '{op: OP_EMIT,        cond: C_OUT_FREE,  target: UPC_WAIT};
      UPC_RETRY:       uw = '{op: OP_NOP,         cond: C_ALWAYS,    target: UPC_DONE};
      default:         uw = '{op: OP_NOP,         cond: C_ALWAYS,    target: UPC_WAIT};
    endcase
    return uw;
  endfunction

endpackage

// ===== rtl/bed_sequencer.sv =====
module bed_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  out_free,
  input  bed_pkg::bed_stat_t    stat,
  output bed_pkg::bed_uword_t   uw
);
  import bed_pkg::*;

  bed_upc_t upc;
  bed_upc_t upc_next;
  logic     take;

  // control word for the current step
  assign uw = bed_ucode(upc);

  // branch decision and next address
  always_comb begin
    case (uw.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_START:  take = !start;
      C_LT_PERIOD: take = stat.lt_period;
      C_CNT_NZ:    take = stat.cnt_nz;
      C_DISABLED:  take = stat.disabled;
      C_NOT_FELL:  take = stat.not_fell;
      C_OUT_FREE:  take = out_free;
      default:     take = 1'b0;
    endcase
    upc_next = take ? uw.target : upc + bed_upc_t'(1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== rtl/bed_datapath.sv =====
module bed_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bed_pkg::bed_in_t  item,
  input  bed_pkg::bed_cfg_t cfg,
  input  bed_pkg::bed_op_t  op,
  output bed_pkg::bed_stat_t stat,
  output bed_pkg::bed_out_t res
);
  import bed_pkg::*;

  // channel state
  logic [TIME_W-1:0]  last_sample_time;
  logic               level;
  logic [COUNT_W-1:0] press_count;
  logic [TIME_W-1:0]  multi_start;
  logic               pressed;
  logic               holding;
  logic [TIME_W-1:0]  hold_start;

  // per-transaction working registers
  logic [TIME_W-1:0]   now_r;
  logic                raw_r;
  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W-1:0]   quo;
  logic [PERIOD_W-1:0] rem;
  logic [CNT_W-1:0]    cnt;
  logic [MASK_W-1:0]   ev;
  logic                took;

  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W:0]   trial;
  logic                trial_ge;
  logic                lv;
  logic                win_exp;
  logic                hold_exp;
  logic [MASK_W-1:0]   ev_masked;

  // a zero period acts as one
  assign period = (cfg.sample_period == '0) ? PERIOD_W'(1) : cfg.sample_period;

  // shift-subtract remainder step
  assign trial    = {rem, quo[TIME_W-1]};
  assign trial_ge = trial >= {1'b0, period};

  assign lv        = raw_r ^ cfg.invert_input;
  assign win_exp   = (now_r - multi_start) > cfg.multi_window;
  assign hold_exp  = (now_r - hold_start) >= cfg.hold_delay;
  assign ev_masked = ev & cfg.event_mask;

  assign stat.lt_period = elapsed < {{(TIME_W-PERIOD_W){1'b0}}, period};
  assign stat.disabled  = !cfg.channel_enable;
  // a press is a change from released to low, seen before level updates
  assign stat.not_fell  = lv || !level;
  assign stat.cnt_nz    = cnt != '0;

  assign res.sampled     = took;
  assign res.ev_change   = ev[EV_CHANGE];
  assign res.ev_falling  = ev[EV_FALLING];
  assign res.ev_rising   = ev[EV_RISING];
  assign res.ev_hold     = ev[EV_HOLD];
  assign res.ev_multi    = ev[EV_MULTI];
  assign res.click_count = press_count;

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_WAIT: begin
        if (start) begin
          now_r <= item.now_ms;
          raw_r <= item.raw_level;
        end
      end
      OP_LOAD: begin
        elapsed <= now_r - last_sample_time;
        quo     <= now_r - last_sample_time;
        rem     <= '0;
        cnt     <= CNT_W'(DIV_STEPS - 1);
        ev      <= '0;
        took    <= 1'b0;
      end
      OP_DIV: begin
        rem <= trial_ge ? PERIOD_W'(trial - {1'b0, period}) : trial[PERIOD_W-1:0];
        quo <= {quo[TIME_W-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
      end
      OP_EDGE: begin
        took <= 1'b1;
        if (lv != level) begin
          ev[EV_CHANGE] <= 1'b1;
          if (lv) begin
            ev[EV_RISING] <= 1'b1;
          end else begin
            ev[EV_FALLING] <= 1'b1;
          end
        end
      end
      OP_PRESS_MULTI: begin
        if (press_count >= cfg.multi_count && !cfg.reload_mode) begin
          ev[EV_MULTI] <= 1'b1;
        end
      end
      OP_RELOAD: begin
        if (cfg.reload_mode && press_count != '0 && win_exp &&
            press_count >= cfg.multi_count) begin
          ev[EV_MULTI] <= 1'b1;
        end
      end
      OP_HOLD: begin
        if (!level && pressed && !holding && hold_exp) begin
          ev[EV_HOLD] <= 1'b1;
        end
      end
      OP_MASK: begin
        ev <= ev_masked;
      end
      default: begin
      end
    endcase
  end

  // channel state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      level            <= 1'b1;
      press_count      <= '0;
      multi_start      <= '0;
      pressed          <= 1'b0;
      holding          <= 1'b0;
      hold_start       <= '0;
    end else begin
      case (op)
        OP_ADVANCE: begin
          // last + (elapsed - rem) reduces to now - rem
          last_sample_time <= now_r - {{(TIME_W-PERIOD_W){1'b0}}, rem};
        end
        OP_EDGE: begin
          level <= lv;
        end
        OP_PRESS_WIN: begin
          if (cfg.reload_mode) begin
            multi_start <= now_r;
          end else if (win_exp) begin
            press_count <= '0;
            multi_start <= now_r;
          end
        end
        OP_PRESS_INC: begin
          press_count <= press_count + COUNT_W'(1);
        end
        OP_PRESS_MULTI: begin
          if (press_count >= cfg.multi_count && !cfg.reload_mode) begin
            multi_start <= now_r;
          end
        end
        OP_RELOAD: begin
          if (cfg.reload_mode && press_count != '0 && win_exp &&
              press_count < cfg.multi_count) begin
            press_count <= '0;
          end
        end
        OP_HOLD: begin
          if (!level && !pressed) begin
            holding    <= 1'b0;
            pressed    <= 1'b1;
            hold_start <= now_r;
          end else if (!level && pressed) begin
            if (!holding && hold_exp) begin
              holding    <= 1'b1;
              hold_start <= now_r;
            end
          end else if (level && pressed) begin
            holding <= 1'b0;
            pressed <= 1'b0;
          end
        end
        OP_MASK: begin
          if (ev_masked[EV_MULTI]) begin
            press_count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/button_event_detector.sv =====
// Button event detector for one channel. Each transaction on the item port
// carries the millisecond time and the raw pin level (1 released, 0 pressed)
// and yields exactly one result with the sampled flag, the change, falling,
// rising, hold and multi-click events gated by event_mask, and the press
// count. A small microcode program steps a plain datapath; the time
// advance needs elapsed modulo the sample period, done by a 32-step
// shift-subtract loop. The emit step registers the result; it follows
// the check when no sample is due, the loop and advance when the channel
// is disabled, and those plus the edge, reload, hold and mask steps when a
// sample is taken, with the press window, increment and multi steps before
// reload for a press. Emit waits while the result side stalls. The next item
// is accepted while the previous result still waits in the output register.
// The item port stalls during reset. Configuration writes are taken in any
// cycle and must be made only while no transaction is in progress.
module button_event_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  bed_pkg::bed_in_t                  item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bed_pkg::bed_out_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bed_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bed_pkg::DATA_W-1:0]        cfg_data
);
  import bed_pkg::*;

  bed_cfg_t   cfg;
  bed_uword_t uw;
  bed_stat_t  stat;
  bed_out_t   dp_res;
  logic       start;
  logic       out_free;
  logic       emit;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period  <= DEFAULT_PERIOD;
      cfg.invert_input   <= 1'b0;
      cfg.hold_delay     <= '0;
      cfg.multi_count    <= '0;
      cfg.multi_window   <= '0;
      cfg.reload_mode    <= 1'b0;
      cfg.channel_enable <= 1'b1;
      cfg.event_mask     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (bed_cfg_idx_t'(cfg_index))
        CFG_SAMPLE_PERIOD:  cfg.sample_period  <= cfg_data[PERIOD_W-1:0];
        CFG_INVERT_INPUT:   cfg.invert_input   <= cfg_data[0];
        CFG_HOLD_DELAY:     cfg.hold_delay     <= cfg_data[TIME_W-1:0];
        CFG_MULTI_COUNT:    cfg.multi_count    <= cfg_data[COUNT_W-1:0];
        CFG_MULTI_WINDOW:   cfg.multi_window   <= cfg_data[TIME_W-1:0];
        CFG_RELOAD_MODE:    cfg.reload_mode    <= cfg_data[0];
        CFG_CHANNEL_ENABLE: cfg.channel_enable <= cfg_data[0];
        CFG_EVENT_MASK:     cfg.event_mask     <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake glue
  assign item_stall = rst || (uw.op != OP_WAIT);
  assign start      = item_valid && !item_stall;
  assign out_free   = !(result_valid && result_stall);
  assign emit       = (uw.op == OP_EMIT) && out_free;

  bed_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .stat     (stat),
    .uw       (uw)
  );

  bed_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .cfg   (cfg),
    .op    (uw.op),
    .stat  (stat),
    .res   (dp_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= dp_res;
    end
  end

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    emit |-> !(result_valid && result_stall))
    else $error("result overwritten while stalled");

  // one transaction in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("second item accepted while busy");

  // no events without a sample
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.sampled) |->
      !(result.ev_change || result.ev_falling || result.ev_rising ||
        result.ev_hold || result.ev_multi))
    else $error("event reported on an unsampled step");

  // a reported multi event clears the press count
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.ev_multi) |-> (result.click_count == '0))
    else $error("press count not cleared after multi event");

endmodule

// ===== tb/button_event_detector_test.sv =====
module button_event_detector_test;
  import bed_pkg::*;

  localparam int HOLDOFF     = 50;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 30;
  localparam int WRAP_ITEMS  = 530;
  localparam int QUIET_TAIL  = 90;
  localparam int PLAN_ROWS   = 39;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // one line of the directed plan: a register write or a sample transaction
  typedef struct packed {
    row_kind_t    kind;
    bed_cfg_idx_t idx;
    logic [31:0]  data;
    bed_in_t      x;
    logic         known;
    bed_out_t     typed;
  } plan_row_t;

  // button state as the detector keeps it
  typedef struct {
    logic [31:0] last_sample;
    logic        level;
    logic [7:0]  presses;
    logic [31:0] multi_start;
    logic        pressed;
    logic        holding;
    logic [31:0] hold_start;
  } button_state_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  bed_in_t     item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  bed_out_t    result;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  bed_cfg_t      cfg_shadow;
  button_state_t btn;
  bed_out_t      due_reports[$];
  int            bad_results = 0;
  bit            quiet = 1'b0;
  bit            in_flight = 1'b0;
  logic [31:0]   clock_ms = '0;
  logic          pin = 1'b1;

  button_event_detector dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // directed plan; flags are {sampled, change, falling, rising, hold, multi}
  plan_row_t plan [0:PLAN_ROWS-1] = '{
    // reset settings: nothing due yet, then a quiet sample
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd0, 1'b1, 1'b1, 6'b000000, 8'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd49, 1'b0, 1'b1, 6'b000000, 8'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd50, 1'b1, 1'b1, 6'b100000, 8'd0},
    // all events on: press with zero multi count, hold, release
    {ROW_REG, CFG_EVENT_MASK, 32'd31, 33'd0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd100, 1'b0, 1'b1, 6'b111001, 8'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd150, 1'b0, 1'b1, 6'b100010, 8'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd200, 1'b1, 1'b1, 6'b110100, 8'd0},
    // inverted pin
    {ROW_REG, CFG_INVERT_INPUT, 32'd1, 33'd0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd250, 1'b1, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd300, 1'b0, 1'b0, 14'd0},
    // zero period behaves as one
    {ROW_REG, CFG_INVERT_INPUT, 32'd0, 33'd0, 1'b0, 14'd0},
    {ROW_REG, CFG_SAMPLE_PERIOD, 32'd0, 33'd0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd301, 1'b0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd301, 1'b1, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd302, 1'b1, 1'b0, 14'd0},
    // widest count, window and hold delay
    {ROW_REG, CFG_MULTI_COUNT, 32'd255, 33'd0, 1'b0, 14'd0},
    {ROW_REG, CFG_MULTI_WINDOW, 32'hFFFF_FFFF, 33'd0, 1'b0, 14'd0},
    {ROW_REG, CFG_HOLD_DELAY, 32'hFFFF_FFFF, 33'd0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd303, 1'b0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd304, 1'b1, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd305, 1'b0, 1'b0, 14'd0},
    // reload mode: window expiry short of the count, then reaching it
    {ROW_REG, CFG_RELOAD_MODE, 32'd1, 33'd0, 1'b0, 14'd0},
    {ROW_REG, CFG_MULTI_WINDOW, 32'd0, 33'd0, 1'b0, 14'd0},
    {ROW_REG, CFG_MULTI_COUNT, 32'd2, 33'd0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd306, 1'b1, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd310, 1'b0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd311, 1'b0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd312, 1'b1, 1'b0, 14'd0},
    {ROW_REG, CFG_MULTI_COUNT, 32'd1, 33'd0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd320, 1'b0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'd321, 1'b0, 1'b0, 14'd0},
    // widest period across the time wrap
    {ROW_REG, CFG_SAMPLE_PERIOD, 32'd65535, 33'd0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'h0000_FFFF, 1'b0, 1'b0, 14'd0},
    // disabled channel
    {ROW_REG, CFG_CHANNEL_ENABLE, 32'd0, 33'd0, 1'b0, 14'd0},
    {ROW_ITEM, CFG_SAMPLE_PERIOD, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 14'd0},
    {ROW_REG, CFG_CHANNEL_ENABLE, 32'd1, 33'd0, 1'b0, 14'd0},
    {ROW_REG, CFG_RELOAD_MODE, 32'd0, 33'd0, 1'b0, 14'd0},
    {ROW_REG, CFG_EVENT_MASK, 32'd0, 33'd0, 1'b0, 14'd0}
  };

  // next result of the detector for one sample, advancing the button state
  function automatic bed_out_t decode_button(bed_in_t x);
    logic [31:0] span;
    logic [31:0] elapsed;
    logic        lv;
    logic [4:0]  ev;
    bed_out_t    r;
    span    = (cfg_shadow.sample_period == '0) ? 32'd1 : {16'd0, cfg_shadow.sample_period};
    elapsed = x.now_ms - btn.last_sample;
    ev      = '0;
    r       = '0;
    if (elapsed >= span) begin
      btn.last_sample = btn.last_sample + (elapsed - (elapsed % span));
      if (cfg_shadow.channel_enable) begin
        lv = x.raw_level ^ cfg_shadow.invert_input;
        r.sampled = 1'b1;
        // edges; a press opens or extends a click run
        if (lv != btn.level) begin
          btn.level = lv;
          ev[EV_CHANGE] = 1'b1;
          if (lv) begin
            ev[EV_RISING] = 1'b1;
          end else begin
            ev[EV_FALLING] = 1'b1;
            if (cfg_shadow.reload_mode) begin
              btn.multi_start = x.now_ms;
            end else if (x.now_ms - btn.multi_start > cfg_shadow.multi_window) begin
              btn.presses = '0;
              btn.multi_start = x.now_ms;
            end
            btn.presses = btn.presses + 8'd1;
            if (btn.presses >= cfg_shadow.multi_count && !cfg_shadow.reload_mode) begin
              btn.multi_start = x.now_ms;
              ev[EV_MULTI] = 1'b1;
            end
          end
        end
        // reload mode settles the run once the window has run out
        if (cfg_shadow.reload_mode && btn.presses != '0 &&
            x.now_ms - btn.multi_start > cfg_shadow.multi_window) begin
          if (btn.presses < cfg_shadow.multi_count)
            btn.presses = '0;
          else
            ev[EV_MULTI] = 1'b1;
        end
        // hold tracking
        if (!btn.level && !btn.pressed) begin
          btn.holding = 1'b0;
          btn.pressed = 1'b1;
          btn.hold_start = x.now_ms;
        end else if (!btn.level && btn.pressed) begin
          if (!btn.holding && x.now_ms - btn.hold_start >= cfg_shadow.hold_delay) begin
            btn.holding = 1'b1;
            btn.hold_start = x.now_ms;
            ev[EV_HOLD] = 1'b1;
          end
        end else if (btn.level && btn.pressed) begin
          btn.holding = 1'b0;
          btn.pressed = 1'b0;
        end
        ev = ev & cfg_shadow.event_mask;
        if (ev[EV_MULTI])
          btn.presses = '0;
      end
    end
    r.ev_change   = ev[EV_CHANGE];
    r.ev_falling  = ev[EV_FALLING];
    r.ev_rising   = ev[EV_RISING];
    r.ev_hold     = ev[EV_HOLD];
    r.ev_multi    = ev[EV_MULTI];
    r.click_count = btn.presses;
    return r;
  endfunction

  function automatic string show_result(bed_out_t r);
    return $sformatf("smp=%0b chg=%0b fall=%0b rise=%0b hold=%0b multi=%0b count=%0d",
                     r.sampled, r.ev_change, r.ev_falling, r.ev_rising, r.ev_hold,
                     r.ev_multi, r.click_count);
  endfunction

  // time value or span for the hold delay and the click window
  function automatic logic [31:0] pick_span(int unsigned span, int unsigned reach);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, reach * span);
    endcase
  endfunction

  // let every pending transaction come out before touching a register
  task automatic settle_block();
    if (in_flight) begin
      item_valid <= 1'b0;
      while (due_reports.size() != 0)
        @(posedge clk);
      repeat (HOLDOFF) @(posedge clk);
      in_flight = 1'b0;
    end
  endtask

  task automatic write_reg(bed_cfg_idx_t idx, logic [31:0] data);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SAMPLE_PERIOD:  cfg_shadow.sample_period  = data[PERIOD_W-1:0];
      CFG_INVERT_INPUT:   cfg_shadow.invert_input   = data[0];
      CFG_HOLD_DELAY:     cfg_shadow.hold_delay     = data;
      CFG_MULTI_COUNT:    cfg_shadow.multi_count    = data[COUNT_W-1:0];
      CFG_MULTI_WINDOW:   cfg_shadow.multi_window   = data;
      CFG_RELOAD_MODE:    cfg_shadow.reload_mode    = data[0];
      CFG_CHANNEL_ENABLE: cfg_shadow.channel_enable = data[0];
      CFG_EVENT_MASK:     cfg_shadow.event_mask     = data[MASK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one sample transaction; the typed result replaces the prediction when given
  task automatic send_sample(bed_in_t x, logic known, bed_out_t typed);
    bed_out_t want;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    item       <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    want = decode_button(x);
    due_reports.push_back(known ? typed : want);
    in_flight = 1'b1;
  endtask

  // one random phase: fresh settings, then a button pattern with random timing
  task automatic run_phase(int count, bit wrap);
    logic [15:0] period;
    int unsigned span;
    logic [31:0] step;
    bed_in_t     x;
    int          n;
    case ($urandom_range(0, 5))
      0: period = 16'd0;
      1: period = 16'd1;
      2: period = 16'($urandom_range(2, 60));
      3: period = 16'hFFFF;
      4: period = DEFAULT_PERIOD;
      default: period = 16'($urandom);
    endcase
    if (wrap)
      period = 16'($urandom_range(0, 3));
    span = (period == 16'd0) ? 1 : period;
    write_reg(CFG_SAMPLE_PERIOD, {16'd0, period});
    write_reg(CFG_INVERT_INPUT, 32'($urandom_range(0, 1)));
    write_reg(CFG_HOLD_DELAY, pick_span(span, 4));
    write_reg(CFG_MULTI_WINDOW, wrap ? 32'hFFFF_FFFF : pick_span(span, 6));
    case ($urandom_range(0, 3))
      0: write_reg(CFG_MULTI_COUNT, 32'd0);
      1: write_reg(CFG_MULTI_COUNT, 32'd255);
      2: write_reg(CFG_MULTI_COUNT, 32'($urandom_range(0, 255)));
      default: write_reg(CFG_MULTI_COUNT, 32'($urandom_range(1, 4)));
    endcase
    write_reg(CFG_RELOAD_MODE, wrap ? 32'd0 : 32'($urandom_range(0, 1)));
    write_reg(CFG_CHANNEL_ENABLE, (wrap || $urandom_range(0, 9) != 0) ? 32'd1 : 32'd0);
    // the long run keeps multi unreported so the count can wrap
    if (wrap)
      write_reg(CFG_EVENT_MASK, 32'($urandom_range(0, 15)));
    else if ($urandom_range(0, 1) == 0)
      write_reg(CFG_EVENT_MASK, 32'd31);
    else
      write_reg(CFG_EVENT_MASK, 32'($urandom_range(0, 31)));

    for (n = 0; n < count; n++) begin
      if (wrap) begin
        step = span + $urandom_range(0, 2);
        if ($urandom_range(0, 99) >= 3)
          pin = ~pin;
        quiet = (n >= count - QUIET_TAIL);
      end else begin
        case ($urandom_range(0, 9))
          0: step = 32'd0;
          1: step = span;
          2: step = $urandom;
          default: step = $urandom_range(0, 2 * span);
        endcase
        if ($urandom_range(0, 99) < 35)
          pin = ~pin;
      end
      clock_ms = clock_ms + step;
      x.now_ms = clock_ms;
      x.raw_level = pin;
      send_sample(x, 1'b0, '0);
    end
  endtask

  // result side: random stall bursts and the check against the oldest expectation
  always @(posedge clk) begin : drain_results
    int       stall_left;
    bed_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_reports.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result: %s", show_result(result));
        bad_results++;
      end else begin
        want = due_reports.pop_front();
        if (result !== want) begin
          if (bad_results < 10)
            $display("result mismatch: expected %s, got %s", show_result(want),
                     show_result(result));
          bad_results++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    int k;
    cfg_shadow = '0;
    cfg_shadow.sample_period  = DEFAULT_PERIOD;
    cfg_shadow.channel_enable = 1'b1;
    btn.last_sample = '0;
    btn.level       = 1'b1;
    btn.presses     = '0;
    btn.multi_start = '0;
    btn.pressed     = 1'b0;
    btn.holding     = 1'b0;
    btn.hold_start  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed plan
    for (k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].kind == ROW_REG) begin
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_sample(plan[k].x, plan[k].known, plan[k].typed);
        clock_ms = plan[k].x.now_ms;
        pin      = plan[k].x.raw_level;
      end
    end

    // random phases, then the long run that wraps the press count
    for (k = 0; k < PHASES; k++)
      run_phase(PHASE_ITEMS, 1'b0);
    run_phase(WRAP_ITEMS, 1'b1);

    item_valid <= 1'b0;
    while (due_reports.size() != 0)
      @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
    if (bad_results == 0 && due_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("Verification failed");
    $finish;
  end

endmodule
